// ----- src/rtlp_pkg.sv -----
// ----------------------------------------------------------------------------
// rtlp_pkg: shared types and codes for the longest-prefix route table
// Command and status codes, the queued command record and the slot record.
// ----------------------------------------------------------------------------
`default_nettype none

package rtlp_pkg;

  localparam int CMD_W    = 2;
  localparam int DEST_W   = 32;
  localparam int PFX_W    = 6;
  localparam int HOP_W    = 32;
  localparam int COST_W   = 16;
  localparam int KIND_W   = 8;
  localparam int TAG_W    = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // one route as held in a table slot
  typedef struct packed {
    logic [DEST_W-1:0] dest;
    logic [PFX_W-1:0]  prefix;
    logic [HOP_W-1:0]  hop;
    logic [COST_W-1:0] cost;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // decoded command as handed from front to back
  typedef struct packed {
    logic              is_insert;
    logic              is_remove;
    logic              is_update;
    logic              is_lookup;
    entry_t            route;
    logic [COST_W-1:0] fresh;
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/route_table_longest_prefix.sv -----
// ----------------------------------------------------------------------------
// route_table_longest_prefix: route table with longest-prefix lookup
// Insert, remove, update-metric and lookup commands over a slot table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the command fields and raise push; the item is
//   taken on a clock edge with push high and full low. A two-deep command
//   queue sits in front of the scan engine, so items can be queued while
//   a command is still being worked on.
//   Result channel: while empty is low the oldest result is on status,
//   hop_out, tag_out and slot_out; it is taken on an edge with pop high.
//   Throughput: every command walks all TABLE_DEPTH slots once through
//   the slot RAM's single read port, one slot per cycle, plus a start, a
//   drain and a write-back step; the engine works on one item at a time.
//   Reset (rst, synchronous) empties the queue and the result register and
//   marks every slot free; slot contents need no clearing.
//   If the receiver stalls, the finished result waits in the output register
//   and the engine holds its write-back until it is taken; the queue then
//   fills and full stays high until room frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module route_table_longest_prefix #(
  parameter int TABLE_DEPTH = 32,
  parameter int ADDR_BITS   = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [rtlp_pkg::CMD_W-1:0]    cmd,
  input  wire logic [rtlp_pkg::DEST_W-1:0]   dest_addr,
  input  wire logic [rtlp_pkg::PFX_W-1:0]    prefix_len,
  input  wire logic [rtlp_pkg::HOP_W-1:0]    hop_addr,
  input  wire logic [rtlp_pkg::COST_W-1:0]   route_metric,
  input  wire logic [rtlp_pkg::KIND_W-1:0]   route_kind,
  input  wire logic [rtlp_pkg::TAG_W-1:0]    route_tag,
  input  wire logic [rtlp_pkg::COST_W-1:0]   fresh_metric,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [rtlp_pkg::STATUS_W-1:0]      status,
  output logic [rtlp_pkg::HOP_W-1:0]         hop_out,
  output logic [rtlp_pkg::TAG_W-1:0]         tag_out,
  output logic [rtlp_pkg::SLOT_W-1:0]        slot_out
);

  logic           q_valid;
  logic           q_pop;
  rtlp_pkg::cmd_t q_data;

  // front: decode and queue items
  rtlp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .dest_addr    (dest_addr),
    .prefix_len   (prefix_len),
    .hop_addr     (hop_addr),
    .route_metric (route_metric),
    .route_kind   (route_kind),
    .route_tag    (route_tag),
    .fresh_metric (fresh_metric),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop)
  );

  // back: slot scan, table update and result register
  rtlp_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .status   (status),
    .hop_out  (hop_out),
    .tag_out  (tag_out),
    .slot_out (slot_out)
  );

endmodule

`default_nettype wire

// ----- src/rtlp_ram.sv -----
// ----------------------------------------------------------------------------
// rtlp_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rtlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/rtlp_front.sv -----
// ----------------------------------------------------------------------------
// rtlp_front: command intake
// Decodes each item into a command record and holds it in a two-deep queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rtlp_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [rtlp_pkg::CMD_W-1:0]    cmd,
  input  wire logic [rtlp_pkg::DEST_W-1:0]   dest_addr,
  input  wire logic [rtlp_pkg::PFX_W-1:0]    prefix_len,
  input  wire logic [rtlp_pkg::HOP_W-1:0]    hop_addr,
  input  wire logic [rtlp_pkg::COST_W-1:0]   route_metric,
  input  wire logic [rtlp_pkg::KIND_W-1:0]   route_kind,
  input  wire logic [rtlp_pkg::TAG_W-1:0]    route_tag,
  input  wire logic [rtlp_pkg::COST_W-1:0]   fresh_metric,
  output logic                               q_valid,
  output rtlp_pkg::cmd_t                     q_data,
  input  wire logic                          q_pop
);

  rtlp_pkg::cmd_t slots [2];
  rtlp_pkg::cmd_t dec;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  always_comb begin
    dec              = '0;
    dec.route.dest   = dest_addr;
    dec.route.prefix = prefix_len;
    dec.route.hop    = hop_addr;
    dec.route.cost   = route_metric;
    dec.route.kind   = route_kind;
    dec.route.tag    = route_tag;
    dec.fresh        = fresh_metric;
    unique case (cmd)
      rtlp_pkg::CMD_INSERT: dec.is_insert = 1'b1;
      rtlp_pkg::CMD_REMOVE: dec.is_remove = 1'b1;
      rtlp_pkg::CMD_UPDATE: dec.is_update = 1'b1;
      default:              dec.is_lookup = 1'b1;
    endcase
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data  = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ----- src/rtlp_back.sv -----
// ----------------------------------------------------------------------------
// rtlp_back: table scan engine
// Walks every slot once per command, then writes the table and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rtlp_back #(
  parameter int TABLE_DEPTH = 32,
  parameter int ADDR_BITS   = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_valid,
  input  wire rtlp_pkg::cmd_t                 q_data,
  output logic                                q_pop,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [rtlp_pkg::STATUS_W-1:0]       status,
  output logic [rtlp_pkg::HOP_W-1:0]          hop_out,
  output logic [rtlp_pkg::TAG_W-1:0]          tag_out,
  output logic [rtlp_pkg::SLOT_W-1:0]         slot_out
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(ADDR_BITS + 1);
  localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                  state;
  rtlp_pkg::cmd_t              cur;
  logic [IW-1:0]               cnt;
  logic [TABLE_DEPTH-1:0]      valid;
  logic                        dv;
  logic                        dv_last;
  logic [IW-1:0]               dv_idx;
  logic                        vld_q;
  rtlp_pkg::entry_t            rd;
  logic                        found;
  logic [IW-1:0]               best_s;
  logic [PW-1:0]               best_p;
  logic [rtlp_pkg::COST_W-1:0] best_c;
  logic [rtlp_pkg::HOP_W-1:0]  best_hop;
  logic                        out_valid;

  logic                        we;
  rtlp_pkg::entry_t            wdata;
  logic                        key_eq;
  logic                        pfx_match;
  logic [PW-1:0]               eff;
  logic [ADDR_BITS-1:0]        mask;
  logic                        take;
  logic                        res_load;
  logic [rtlp_pkg::STATUS_W-1:0] status_next;

  rtlp_ram #(
    .WIDTH ($bits(rtlp_pkg::entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (best_s),
    .wdata (wdata),
    .raddr (cnt),
    .rdata (rd)
  );

  // slot classification for the entry coming out of the RAM
  always_comb begin
    key_eq    = (rd == cur.route);
    eff       = (int'(rd.prefix) > ADDR_BITS) ? PW'(ADDR_BITS) : PW'(rd.prefix);
    mask      = ~({ADDR_BITS{1'b1}} >> eff);
    pfx_match = (((ADDR_BITS'(rd.dest) ^ ADDR_BITS'(cur.route.dest)) & mask) == '0);
    take      = 1'b0;
    if (dv) begin
      if (cur.is_insert) begin
        take = !vld_q && !found;
      end else if (cur.is_lookup) begin
        take = vld_q && pfx_match &&
               (!found || eff > best_p || (eff == best_p && rd.cost < best_c));
      end else begin
        take = vld_q && key_eq && !found;
      end
    end
  end

  assign res_load = (state == S_DONE) && (!out_valid || pop);
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign empty    = !out_valid;
  assign we       = res_load && found && (cur.is_insert || cur.is_update);

  always_comb begin
    wdata = cur.route;
    if (cur.is_update) wdata.cost = cur.fresh;
  end

  always_comb begin
    if (found)              status_next = rtlp_pkg::ST_OK;
    else if (cur.is_insert) status_next = rtlp_pkg::ST_FULL;
    else                    status_next = rtlp_pkg::ST_MISS;
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
    vld_q  <= valid[cnt];
    dv_idx <= cnt;
    if (take) begin
      best_s   <= dv_idx;
      best_p   <= eff;
      best_c   <= rd.cost;
      best_hop <= rd.hop;
    end
    if (res_load) begin
      status   <= status_next;
      hop_out  <= (found && cur.is_lookup) ? best_hop : '0;
      tag_out  <= (found && cur.is_remove) ? cur.route.tag : '0;
      slot_out <= found ? rtlp_pkg::SLOT_W'(best_s) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      valid     <= '0;
      dv        <= 1'b0;
      dv_last   <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      dv      <= (state == S_SCAN);
      dv_last <= (state == S_SCAN) && (cnt == LAST);
      if (take) found <= 1'b1;
      if (pop && out_valid && !res_load) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_SCAN;
            cnt   <= '0;
            found <= 1'b0;
          end
        end
        S_SCAN: begin
          if (cnt == LAST) state <= S_DRAIN;
          else             cnt   <= cnt + 1'b1;
        end
        S_DRAIN: begin
          if (dv && dv_last) state <= S_DONE;
        end
        default: begin
          if (res_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (found && cur.is_insert) valid[best_s] <= 1'b1;
            if (found && cur.is_remove) valid[best_s] <= 1'b0;
          end
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_full_only_insert: assert property (@(posedge clk) disable iff (rst)
    res_load && status_next == rtlp_pkg::ST_FULL |-> cur.is_insert)
    else $error("table full reported for a non-insert command");
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !out_valid || pop)
    else $error("result overwritten before being taken");
  a_data_in_scan: assert property (@(posedge clk) disable iff (rst)
    dv |-> state == S_SCAN || state == S_DRAIN)
    else $error("slot data arrived outside a scan");
  a_write_needs_found: assert property (@(posedge clk) disable iff (rst)
    we |-> found && state == S_DONE)
    else $error("table write without a chosen slot");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the longest-prefix route table
// Directed table of commands, then random traffic built around a shadow copy
// of the routes, checked item by item against an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH       = 32;
  localparam int N_RANDOM    = 600;
  localparam int CYC_LIMIT   = 400000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [rtlp_pkg::CMD_W-1:0]    cmd = rtlp_pkg::CMD_INSERT;
  logic [rtlp_pkg::DEST_W-1:0]   dest_addr = '0;
  logic [rtlp_pkg::PFX_W-1:0]    prefix_len = '0;
  logic [rtlp_pkg::HOP_W-1:0]    hop_addr = '0;
  logic [rtlp_pkg::COST_W-1:0]   route_metric = '0;
  logic [rtlp_pkg::KIND_W-1:0]   route_kind = '0;
  logic [rtlp_pkg::TAG_W-1:0]    route_tag = '0;
  logic [rtlp_pkg::COST_W-1:0]   fresh_metric = '0;
  logic [rtlp_pkg::STATUS_W-1:0] status;
  logic [rtlp_pkg::HOP_W-1:0]    hop_out;
  logic [rtlp_pkg::TAG_W-1:0]    tag_out;
  logic [rtlp_pkg::SLOT_W-1:0]   slot_out;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  route_table_longest_prefix dut (
    .clk, .rst, .push, .full, .cmd, .dest_addr, .prefix_len, .hop_addr,
    .route_metric, .route_kind, .route_tag, .fresh_metric,
    .empty, .pop, .status, .hop_out, .tag_out, .slot_out
  );

  typedef struct packed {
    logic [rtlp_pkg::CMD_W-1:0]  op;
    rtlp_pkg::entry_t            route;
    logic [rtlp_pkg::COST_W-1:0] fresh;
  } route_cmd_t;

  typedef struct packed {
    logic [rtlp_pkg::STATUS_W-1:0] st;
    logic [rtlp_pkg::HOP_W-1:0]    hop;
    logic [rtlp_pkg::TAG_W-1:0]    tag;
    logic [rtlp_pkg::SLOT_W-1:0]   slot;
  } answer_t;

  // shadow route table
  logic             shadow_used [DEPTH];
  rtlp_pkg::entry_t shadow_route[DEPTH];

  answer_t    answers_due[$];
  route_cmd_t pending[$];

  int mismatches = 0;
  int checked    = 0;
  int cycles     = 0;
  int tx_idle    = 0;   // percent of cycles the sender idles
  int rx_idle    = 0;
  bit rx_hold    = 1'b0;
  bit hold_req   = 1'b0;
  int hold_cnt   = 0;
  int n_hits = 0, n_full = 0, n_miss = 0;

  function automatic logic [5:0] eff_len(logic [rtlp_pkg::PFX_W-1:0] p);
    return (p > 6'd32) ? 6'd32 : p;
  endfunction

  function automatic logic [31:0] len_mask(logic [rtlp_pkg::PFX_W-1:0] p);
    logic [5:0] e;
    e = eff_len(p);
    if (e == 0) return 32'h0;
    return 32'hFFFF_FFFF << (32 - e);
  endfunction

  // first valid slot whose six fields equal the command's route, or -1
  function automatic int find_route(rtlp_pkg::entry_t r);
    for (int s = 0; s < DEPTH; s++)
      if (shadow_used[s] && shadow_route[s] == r) return s;
    return -1;
  endfunction

  // apply one command to the shadow table and return its answer
  function automatic answer_t route_answer(route_cmd_t c);
    answer_t a;
    int f;
    bit found;
    logic [5:0] best_p, p;
    logic [rtlp_pkg::COST_W-1:0] best_c;
    int best_s;
    a = '0;
    found = 0; best_p = 0; best_c = 0; best_s = 0;
    case (c.op)
      rtlp_pkg::CMD_INSERT: begin
        a.st = rtlp_pkg::ST_FULL;
        for (int s = 0; s < DEPTH; s++)
          if (!shadow_used[s]) begin
            shadow_used[s] = 1'b1;
            shadow_route[s] = c.route;
            a.st = rtlp_pkg::ST_OK;
            a.slot = s[rtlp_pkg::SLOT_W-1:0];
            break;
          end
      end
      rtlp_pkg::CMD_REMOVE: begin
        f = find_route(c.route);
        if (f < 0) a.st = rtlp_pkg::ST_MISS;
        else begin
          shadow_used[f] = 1'b0;
          a.tag = shadow_route[f].tag;
          a.slot = f[rtlp_pkg::SLOT_W-1:0];
        end
      end
      rtlp_pkg::CMD_UPDATE: begin
        f = find_route(c.route);
        if (f < 0) a.st = rtlp_pkg::ST_MISS;
        else begin
          shadow_route[f].cost = c.fresh;
          a.slot = f[rtlp_pkg::SLOT_W-1:0];
        end
      end
      default: begin
        for (int s = 0; s < DEPTH; s++) begin
          if (!shadow_used[s]) continue;
          if (((shadow_route[s].dest ^ c.route.dest) &
               len_mask(shadow_route[s].prefix)) != 0)
            continue;
          p = eff_len(shadow_route[s].prefix);
          if (!found || p > best_p ||
              (p == best_p && shadow_route[s].cost < best_c)) begin
            found = 1; best_p = p; best_c = shadow_route[s].cost; best_s = s;
          end
        end
        if (found) begin
          a.hop = shadow_route[best_s].hop;
          a.slot = best_s[rtlp_pkg::SLOT_W-1:0];
        end else a.st = rtlp_pkg::ST_MISS;
      end
    endcase
    return a;
  endfunction

  function automatic rtlp_pkg::entry_t rand_route();
    rtlp_pkg::entry_t r;
    r.dest   = $urandom;
    r.prefix = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 3) != 0) r.prefix = 6'($urandom_range(0, 32));
    r.hop    = $urandom;
    r.cost   = 16'($urandom);
    r.kind   = 8'($urandom);
    r.tag    = $urandom;
    return r;
  endfunction

  // queue a command; its expected answer is computed on acceptance
  task automatic offer(route_cmd_t c);
    pending.push_back(c);
  endtask

  // ------------------------------------------------------------------
  // Sender: holds one item on the ports until full is low at an edge
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        answers_due.push_back(route_answer(pending.pop_front()));
      end
      if (pending.size() != 0 && ($urandom_range(0, 99) >= tx_idle || (push && full))) begin
        push         <= 1'b1;
        cmd          <= pending[0].op;
        dest_addr    <= pending[0].route.dest;
        prefix_len   <= pending[0].route.prefix;
        hop_addr     <= pending[0].route.hop;
        route_metric <= pending[0].route.cost;
        route_kind   <= pending[0].route.kind;
        route_tag    <= pending[0].route.tag;
        fresh_metric <= pending[0].fresh;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // the head stays pending until accepted, so a held item is re-driven unchanged
  // (an accepted head was popped above, so pending[0] is already the next one)

  // ------------------------------------------------------------------
  // Receiver hold: counts out a long stall once requested
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (rx_hold) begin
        if (hold_cnt == HOLD_CYCLES - 1) rx_hold <= 1'b0;
        hold_cnt <= hold_cnt + 1;
      end else if (hold_req) begin
        rx_hold  <= 1'b1;
        hold_cnt <= 0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Receiver and checker
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    answer_t e;
    if (!rst) begin
      if (pop && !empty) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item st=%0d slot=%0d", status, slot_out);
        end else begin
          e = answers_due.pop_front();
          checked++;
          if (e.st == rtlp_pkg::ST_OK) n_hits++;
          if (e.st == rtlp_pkg::ST_FULL) n_full++;
          if (e.st == rtlp_pkg::ST_MISS) n_miss++;
          if (status !== e.st || hop_out !== e.hop || tag_out !== e.tag ||
              slot_out !== e.slot) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: exp st=%0d hop=%h tag=%h slot=%0d %s",
                       checked, e.st, e.hop, e.tag, e.slot,
                       $sformatf("got st=%0d hop=%h tag=%h slot=%0d",
                                 status, hop_out, tag_out, slot_out));
          end
        end
      end
      pop <= !rx_hold && ($urandom_range(0, 99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending.size() != 0 || answers_due.size() != 0) @(posedge clk);
  endtask

  // one random command; mostly keys taken from live routes so hits happen
  task automatic random_cmd();
    route_cmd_t c;
    int s;
    logic [31:0] flip;
    c.op = 2'($urandom_range(0, 3));
    c.route = rand_route();
    c.fresh = 16'($urandom);
    s = $urandom_range(0, DEPTH - 1);
    if (shadow_used[s] && $urandom_range(0, 3) != 0) begin
      case (c.op)
        rtlp_pkg::CMD_REMOVE, rtlp_pkg::CMD_UPDATE: c.route = shadow_route[s];
        rtlp_pkg::CMD_LOOKUP: begin
          flip = $urandom & ~len_mask(shadow_route[s].prefix);
          if ($urandom_range(0, 3) == 0) flip = flip | $urandom;
          c.route.dest = shadow_route[s].dest ^ flip;
        end
        default: if ($urandom_range(0, 1)) c.route.dest = shadow_route[s].dest;
      endcase
    end
    offer(c);
  endtask

  // ------------------------------------------------------------------
  // Directed table: expected answer given only where obvious
  // ------------------------------------------------------------------
  typedef struct packed {
    route_cmd_t c;
    bit         known;
    answer_t    a;
  } row_t;

  row_t rows[$];

  task automatic add_row(logic [rtlp_pkg::CMD_W-1:0] op, logic [31:0] d, logic [5:0] p,
                         logic [31:0] h, logic [15:0] m, logic [7:0] k, logic [31:0] t,
                         logic [15:0] f, bit known, logic [1:0] st);
    row_t r;
    r.c.op = op;
    r.c.route = '{dest: d, prefix: p, hop: h, cost: m, kind: k, tag: t};
    r.c.fresh = f;
    r.known = known;
    r.a = '{st: st, hop: '0, tag: '0, slot: '0};
    rows.push_back(r);
  endtask

  initial begin
    route_cmd_t c;
    answer_t a;
    for (int s = 0; s < DEPTH; s++) begin
      shadow_used[s] = 1'b0;
      shadow_route[s] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty table: every key misses
    add_row(rtlp_pkg::CMD_LOOKUP, 32'h0, 0, 0, 0, 0, 0, 0, 1, rtlp_pkg::ST_MISS);
    add_row(rtlp_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 63, '1, '1, '1, '1, 0, 1, rtlp_pkg::ST_MISS);
    add_row(rtlp_pkg::CMD_UPDATE, 32'h0, 0, 0, 0, 0, 0, '1, 1, rtlp_pkg::ST_MISS);
    // default route, then nested prefixes, oversized prefix and a metric tie
    add_row(rtlp_pkg::CMD_INSERT, 32'h0, 0, 32'h1111_1111, 16'hFFFF, 8'h00,
            32'hAAAA_0000, 0, 0, 0);
    add_row(rtlp_pkg::CMD_INSERT, 32'h0A00_0000, 8, 32'h2222_2222, 16'd5, 8'hFF,
            32'hFFFF_FFFF, 0, 0, 0);
    add_row(rtlp_pkg::CMD_INSERT, 32'h0A01_0000, 16, 32'h3333_3333, 16'd9, 8'h01,
            32'h0, 0, 0, 0);
    add_row(rtlp_pkg::CMD_INSERT, 32'h0A01_0000, 16, 32'h4444_4444, 16'd9, 8'h02,
            32'h1, 0, 0, 0);
    add_row(rtlp_pkg::CMD_INSERT, 32'hFFFF_FFFF, 63, 32'hFFFF_FFFF, 16'd0, 8'h80,
            32'h5, 0, 0, 0);
    add_row(rtlp_pkg::CMD_LOOKUP, 32'hC0A8_0001, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(rtlp_pkg::CMD_LOOKUP, 32'h0A02_0304, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(rtlp_pkg::CMD_LOOKUP, 32'h0A01_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(rtlp_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(rtlp_pkg::CMD_UPDATE, 32'h0A01_0000, 16, 32'h4444_4444, 16'd9, 8'h02,
            32'h1, 16'd3, 0, 0);
    add_row(rtlp_pkg::CMD_LOOKUP, 32'h0A01_0203, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(rtlp_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32, 32'hFFFF_FFFF, 16'd0, 8'h80,
            32'h5, 0, 1, rtlp_pkg::ST_MISS);
    add_row(rtlp_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 63, 32'hFFFF_FFFF, 16'd0, 8'h80,
            32'h5, 0, 0, 0);
    add_row(rtlp_pkg::CMD_REMOVE, 32'h0, 0, 32'h1111_1111, 16'hFFFF, 8'h00,
            32'hAAAA_0000, 0, 0, 0);
    add_row(rtlp_pkg::CMD_LOOKUP, 32'hC0A8_0001, 0, 0, 0, 0, 0, 0, 1, rtlp_pkg::ST_MISS);
    add_row(rtlp_pkg::CMD_INSERT, 32'h0, 0, 32'h0, 16'h0, 8'h0, 32'h0, 0, 0, 0);

    // typed-in answers must agree with the predictor, which then checks the block
    foreach (rows[i]) begin
      a = route_answer(rows[i].c);
      if (rows[i].known && a !== rows[i].a) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d: exp st=%0d hop=%h tag=%h slot=%0d got st=%0d",
                   i, rows[i].a.st, rows[i].a.hop, rows[i].a.tag, rows[i].a.slot, a.st);
      end
    end
    // reset shadow and run the rows for real
    for (int s = 0; s < DEPTH; s++) shadow_used[s] = 1'b0;
    foreach (rows[i]) offer(rows[i].c);
    wait_drained();

    // fill to the top so inserts report full, then empty it with removes
    for (int i = 0; i < 40; i++) begin
      c.op = rtlp_pkg::CMD_INSERT; c.route = rand_route(); c.fresh = 16'($urandom);
      offer(c);
    end
    wait_drained();
    for (int s = 0; s < DEPTH; s++) begin
      if (shadow_used[s]) begin
        c.op = rtlp_pkg::CMD_REMOVE; c.route = shadow_route[s]; c.fresh = '0;
        offer(c);
      end
    end
    wait_drained();

    // random phases, the first two with idling on both sides
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 38 : (ph == 1) ? 74 : 0;
      rx_idle = (ph == 0) ? 74 : (ph == 1) ? 38 : 0;
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        while (pending.size() > 4) @(posedge clk);
        random_cmd();
        if (ph == 0 && i == 60) begin
          // receiver holds off long enough for the input queue to fill
          hold_req = 1'b1;
          for (int k = 0; k < 6; k++) random_cmd();
          wait (rx_hold);
          hold_req = 1'b0;
          wait (!rx_hold);
        end
        if (i == 120) wait_drained();
      end
    end
    tx_idle = 0; rx_idle = 0;
    wait_drained();
    repeat (100) @(posedge clk);

    $display("checked %0d result items: %0d ok, %0d miss, %0d full",
             checked, n_hits, n_miss, n_full);
    $display("covered empty, full, nested prefixes, oversized prefix and long receiver stall");
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("mismatches: %0d", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
